### rtl/sprq_pkg.sv
package sprq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PRIO_BITS_DEF   = 8;

    // fixed payload field widths
    localparam int ID_W         = 4;
    localparam int PRIO_FIELD_W = 8;
    localparam int OCC_W        = 5;
    localparam int PRIO_MAX_W   = 16;

    typedef enum logic [0:0] {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } op_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } queue_status_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic [ID_W-1:0]           proc_id;
        logic [PRIO_FIELD_W-1:0]   prio;
    } req_t;

    typedef struct packed {
        queue_status_t             status;
        logic [ID_W-1:0]           head_id;
        logic [PRIO_FIELD_W-1:0]   head_prio;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

endpackage

### rtl/sprq_ram.sv
module sprq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/stable_priority_ready_queue_core.sv
// Dequeue: head read (ST_DEQ), then result register (ST_RESP).
// Enqueue: scans back from the tail, shifting each stored entry it passes over
// one slot toward the tail, one per cycle through the slot RAM read/write ports.
// Full-queue enqueue, empty-queue enqueue and empty-queue dequeue go straight to ST_RESP. One in flight;
// the next is accepted once the previous result has been handed to the output register.
// Reset (rst_n, async low) empties the queue; slot RAM contents are not cleared.
module stable_priority_ready_queue_core #(
    parameter int QUEUE_DEPTH = sprq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIO_BITS   = sprq_pkg::PRIO_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sprq_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sprq_pkg::rsp_t  rsp
);

    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W       = sprq_pkg::ID_W;
    localparam int ENTRY_W    = ID_W + PRIO_BITS;
    localparam int PRIO_MAX_W = sprq_pkg::PRIO_MAX_W;
    localparam int PRIO_FLD_W = sprq_pkg::PRIO_FIELD_W;
    localparam int OCC_W      = sprq_pkg::OCC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_DEQ,
        ST_RESP
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : PTR_W'(p - 1'b1);
    endfunction

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    tail_reg;
    logic [PTR_W-1:0]    cur_reg;
    logic [PTR_W-1:0]    hole_reg;
    logic [CNT_W-1:0]    left_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    sprq_pkg::rsp_t      res_reg;
    sprq_pkg::rsp_t      rsp_reg;
    logic                rsp_valid_reg;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic [PRIO_BITS-1:0] req_prio;
    logic [ENTRY_W-1:0]   new_entry;
    logic [ENTRY_W-1:0]   rd_data;
    logic [ID_W-1:0]      rd_id;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 stop_here;

    logic                 mem_wr_en;
    logic [PTR_W-1:0]     mem_wr_addr;
    logic [ENTRY_W-1:0]   mem_wr_data;
    logic                 mem_rd_en;
    logic [PTR_W-1:0]     mem_rd_addr;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);
    assign req_prio  = PRIO_BITS'(PRIO_MAX_W'(req.prio));
    assign new_entry = {id_reg, prio_reg};
    assign rd_id     = rd_data[ENTRY_W-1:PRIO_BITS];
    assign rd_prio   = rd_data[PRIO_BITS-1:0];
    // new entry goes behind anything of equal or higher priority
    assign stop_here = (rd_prio >= prio_reg);

    sprq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = hole_reg;
        mem_wr_data = new_entry;
        mem_rd_en   = 1'b0;
        mem_rd_addr = ptr_dec(cur_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == sprq_pkg::KIND_ENQ)
                    begin
                        if (!is_full && is_empty)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = tail_reg;
                            mem_wr_data = {req.proc_id, req_prio};
                        end
                        else if (!is_full)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = ptr_dec(tail_reg);
                        end
                    end
                    else if (!is_empty)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_reg;
                    end
                end
            end
            ST_SCAN:
            begin
                mem_wr_en = 1'b1;
                if (!stop_here)
                begin
                    // shift the compared entry one slot toward the tail
                    mem_wr_data = rd_data;
                    if (left_reg != CNT_W'(1))
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ptr_dec(cur_reg);
                    end
                end
            end
            ST_PLACE:
            begin
                mem_wr_en = 1'b1;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_RESP)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_reg.head_id   <= '0;
                        res_reg.head_prio <= '0;
                        res_reg.occupancy <= '0;
                        id_reg   <= req.proc_id;
                        prio_reg <= req_prio;
                        if (req.kind == sprq_pkg::KIND_ENQ)
                        begin
                            if (is_full)
                            begin
                                res_reg.status <= sprq_pkg::STATUS_FULL;
                                state_reg      <= ST_RESP;
                            end
                            else if (is_empty)
                            begin
                                res_reg.status <= sprq_pkg::STATUS_OK;
                                count_reg      <= CNT_W'(count_reg + 1'b1);
                                tail_reg       <= ptr_inc(tail_reg);
                                state_reg      <= ST_RESP;
                            end
                            else
                            begin
                                cur_reg   <= ptr_dec(tail_reg);
                                hole_reg  <= tail_reg;
                                left_reg  <= count_reg;
                                state_reg <= ST_SCAN;
                            end
                        end
                        else if (is_empty)
                        begin
                            res_reg.status <= sprq_pkg::STATUS_EMPTY;
                            state_reg      <= ST_RESP;
                        end
                        else
                        begin
                            state_reg <= ST_DEQ;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (stop_here)
                    begin
                        res_reg.status <= sprq_pkg::STATUS_OK;
                        count_reg      <= CNT_W'(count_reg + 1'b1);
                        tail_reg       <= ptr_inc(tail_reg);
                        state_reg      <= ST_RESP;
                    end
                    else
                    begin
                        hole_reg <= cur_reg;
                        if (left_reg == CNT_W'(1))
                        begin
                            state_reg <= ST_PLACE;
                        end
                        else
                        begin
                            cur_reg  <= ptr_dec(cur_reg);
                            left_reg <= CNT_W'(left_reg - 1'b1);
                        end
                    end
                end
                ST_PLACE:
                begin
                    res_reg.status <= sprq_pkg::STATUS_OK;
                    count_reg      <= CNT_W'(count_reg + 1'b1);
                    tail_reg       <= ptr_inc(tail_reg);
                    state_reg      <= ST_RESP;
                end
                ST_DEQ:
                begin
                    res_reg.status    <= sprq_pkg::STATUS_OK;
                    res_reg.head_id   <= rd_id;
                    res_reg.head_prio <= PRIO_FLD_W'(PRIO_MAX_W'(rd_prio));
                    head_reg          <= ptr_inc(head_reg);
                    count_reg         <= CNT_W'(count_reg - 1'b1);
                    state_reg         <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= {res_reg.status, res_reg.head_id,
                                          res_reg.head_prio, OCC_W'(count_reg)};
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
        else $error("slot read and write hit the same entry");

    a_scan_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (left_reg != '0) && !is_empty && !is_full)
        else $error("insert scan with no entries left to compare");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEQ) |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("dequeue did not drop the entry count by one");

    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && (!rsp_valid_reg || !rsp_stall)) |=>
        (rsp_valid_reg && state_reg == ST_IDLE))
        else $error("result not handed to output register");
`endif

endmodule

### tb/sv/stable_priority_ready_queue_core_test.sv
module stable_priority_ready_queue_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = sprq_pkg::QUEUE_DEPTH_DEF;
    localparam int TOTAL_ITEMS = 1350;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ID_W        = sprq_pkg::ID_W;
    localparam int PF_W        = sprq_pkg::PRIO_FIELD_W;
    localparam int OCC_W       = sprq_pkg::OCC_W;
    localparam logic [PF_W-1:0] PRIO_MASK = PF_W'((1 << sprq_pkg::PRIO_BITS_DEF) - 1);

    typedef struct {
        sprq_pkg::req_t item;
        bit             typed;
        sprq_pkg::rsp_t want;
    } plan_row_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    sprq_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    sprq_pkg::rsp_t rsp;

    // shadow of the ready queue, slot 0 is the head
    logic [ID_W-1:0] rq_ids[DEPTH];
    logic [PF_W-1:0] rq_prios[DEPTH];
    int              rq_count;

    sprq_pkg::rsp_t results_due[$];
    plan_row_t      plan[$];
    int unsigned    sent;
    int unsigned    errors;
    int unsigned    cycle_count;
    bit             hold_request;

    stable_priority_ready_queue_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic sprq_pkg::rsp_t ready_queue_apply(input sprq_pkg::req_t item);
        sprq_pkg::rsp_t  o;
        int              pos;
        int              i;
        logic [PF_W-1:0] p;
        o = '0;
        p = item.prio & PRIO_MASK;
        if (item.kind == sprq_pkg::KIND_ENQ)
        begin
            if (rq_count >= DEPTH)
            begin
                o.status = sprq_pkg::STATUS_FULL;
            end
            else
            begin
                // goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < rq_count && rq_prios[pos] >= p)
                    pos++;
                for (i = rq_count; i > pos; i--)
                begin
                    rq_ids[i]   = rq_ids[i-1];
                    rq_prios[i] = rq_prios[i-1];
                end
                rq_ids[pos]   = item.proc_id;
                rq_prios[pos] = p;
                rq_count++;
                o.status = sprq_pkg::STATUS_OK;
            end
        end
        else if (rq_count == 0)
        begin
            o.status = sprq_pkg::STATUS_EMPTY;
        end
        else
        begin
            o.status    = sprq_pkg::STATUS_OK;
            o.head_id   = rq_ids[0];
            o.head_prio = rq_prios[0];
            for (i = 1; i < rq_count; i++)
            begin
                rq_ids[i-1]   = rq_ids[i];
                rq_prios[i-1] = rq_prios[i];
            end
            rq_count--;
        end
        o.occupancy = OCC_W'(rq_count);
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic void add_row(input sprq_pkg::op_kind_t kind, input int id,
                                    input int prio, input bit typed,
                                    input sprq_pkg::queue_status_t st,
                                    input int hid, input int hprio, input int occ);
        plan_row_t row;
        row.item.kind      = kind;
        row.item.proc_id   = ID_W'(id);
        row.item.prio      = PF_W'(prio);
        row.typed          = typed;
        row.want.status    = st;
        row.want.head_id   = ID_W'(hid);
        row.want.head_prio = PF_W'(hprio);
        row.want.occupancy = OCC_W'(occ);
        plan.push_back(row);
    endfunction

    // call right after a rising edge; returns at the edge of acceptance
    task automatic offer(input sprq_pkg::req_t item, input bit typed,
                         input sprq_pkg::rsp_t typed_rsp);
        sprq_pkg::rsp_t predicted;
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted = ready_queue_apply(item);
        results_due.push_back(typed ? typed_rsp : predicted);
        sent++;
    endtask

    task automatic idle(input int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin : receiver
        int len;
        int quiet_left;
        rsp_stall  = 1'b0;
        quiet_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                len = LONG_HOLD;
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
                len = 0;
            end
            else
            begin
                len = pick_gap();
                if ($urandom_range(149) == 0)
                    quiet_left = $urandom_range(200, 40);
            end
            if (len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        sprq_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected transaction: status %0d head_id %0d head_prio %0d occupancy %0d",
                       rsp.status, rsp.head_id, rsp.head_prio, rsp.occupancy);
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.head_id !== want.head_id)
                begin
                    $error("head_id: expected %0d, actual %0d", want.head_id, rsp.head_id);
                    errors++;
                end
                if (rsp.head_prio !== want.head_prio)
                begin
                    $error("head_prio: expected %0d, actual %0d", want.head_prio, rsp.head_prio);
                    errors++;
                end
                if (rsp.occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp.occupancy);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("stable_priority_ready_queue_core regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        sprq_pkg::req_t item;
        int             k;
        int             phase_len;
        int             enq_pct;
        int             prio_mode;
        bit             calm;
        bit             hold_done;
        bit             pause_done;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        rq_count     = 0;
        foreach (rq_ids[i])
        begin
            rq_ids[i]   = '0;
            rq_prios[i] = '0;
        end

        // empty queue, extremes, ignored fields on dequeue
        add_row(sprq_pkg::KIND_DEQ, 0, 0, 1, sprq_pkg::STATUS_EMPTY, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 0, 0, 1, sprq_pkg::STATUS_OK, 0, 0, 1);
        add_row(sprq_pkg::KIND_ENQ, 15, 255, 1, sprq_pkg::STATUS_OK, 0, 0, 2);
        add_row(sprq_pkg::KIND_DEQ, 0, 0, 1, sprq_pkg::STATUS_OK, 15, 255, 1);
        add_row(sprq_pkg::KIND_DEQ, 15, 255, 1, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_DEQ, 15, 255, 1, sprq_pkg::STATUS_EMPTY, 0, 0, 0);
        // fill up: ties, head inserts, tail inserts
        add_row(sprq_pkg::KIND_ENQ, 0, 10, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 1, 10, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 2, 20, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 3, 5, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 4, 10, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 5, 255, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 6, 0, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 7, 255, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 8, 128, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 9, 128, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 10, 1, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 11, 254, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 12, 10, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 13, 0, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 14, 200, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 15, 50, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_ENQ, 9, 77, 1, sprq_pkg::STATUS_FULL, 0, 0, 16);
        add_row(sprq_pkg::KIND_DEQ, 3, 3, 0, sprq_pkg::STATUS_OK, 0, 0, 0);
        add_row(sprq_pkg::KIND_DEQ, 12, 99, 0, sprq_pkg::STATUS_OK, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            idle(pick_gap());
            offer(plan[i].item, plan[i].typed, plan[i].want);
        end

        while (sent < TOTAL_ITEMS)
        begin
            calm = ($urandom_range(4) == 0);
            if (!hold_done && sent >= 300)
            begin
                // receiver holds off while the sender keeps pushing
                hold_request = 1'b1;
                hold_done    = 1'b1;
                calm         = 1'b1;
            end
            if (!pause_done && sent >= 700)
            begin
                pause_done = 1'b1;
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (results_due.size() != 0);
            end
            phase_len = $urandom_range(80, 20);
            case ($urandom_range(3))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                2:       enq_pct = 50;
                default: enq_pct = 65;
            endcase
            prio_mode = $urandom_range(3);
            for (k = 0; k < phase_len && sent < TOTAL_ITEMS; k++)
            begin
                item.kind    = ($urandom_range(99) < enq_pct) ? sprq_pkg::KIND_ENQ
                                                               : sprq_pkg::KIND_DEQ;
                item.proc_id = ID_W'($urandom);
                case (prio_mode)
                    0:       item.prio = PF_W'($urandom);
                    1:       item.prio = PF_W'($urandom_range(3) * 85);
                    2:       item.prio = ($urandom_range(1) ? 8'hFE : 8'h00)
                                         | PF_W'($urandom_range(1));
                    default: item.prio = PF_W'(100 + $urandom_range(3));
                endcase
                if (!calm)
                    idle(pick_gap());
                offer(item, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
        repeat (DEPTH + 8) @(posedge clk);

        if (errors == 0)
            $display("stable_priority_ready_queue_core regression: pass");
        else
            $display("stable_priority_ready_queue_core regression: fail");
        $finish;
    end

endmodule
